// File: hdl/ted_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ted_pkg;

  localparam int COUNT_W    = 16;
  localparam int POP_W      = 16;
  localparam int SUM_BITS   = 42;
  localparam int DIST_W     = 22;
  // root of sum * 2^32 needs (42 + 32) / 2 bits, one bit per step
  localparam int ROOT_W     = 37;
  localparam int REM_W      = ROOT_W + 3;
  localparam int STEPS      = ROOT_W;
  localparam int STEP_CNT_W = 6;

  localparam logic [SUM_BITS-1:0]   SUM_MAX   = {SUM_BITS{1'b1}};
  localparam logic [DIST_W-1:0]     DIST_MAX  = {DIST_W{1'b1}};
  localparam logic [POP_W-1:0]      POP_RESET = 16'd1000;
  localparam logic [STEP_CNT_W-1:0] LAST_STEP = STEP_CNT_W'(STEPS - 1);

  typedef enum logic [1:0] {
    ST_ACC,
    ST_SQRT,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;       // latch squared difference of an accepted item
    logic sq_en;      // add latched square into the sum
    logic sq_last;    // that square closes the series
    logic sqrt_step;
    logic div_step;
  } lane_ctl_t;

endpackage
`default_nettype wire

// File: hdl/ted_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface ted_in_if;
  logic                         valid;
  logic                         ready;
  logic [ted_pkg::COUNT_W-1:0]  sim_susceptible;
  logic [ted_pkg::COUNT_W-1:0]  sim_infected;
  logic [ted_pkg::COUNT_W-1:0]  sim_recovered;
  logic [ted_pkg::COUNT_W-1:0]  obs_susceptible;
  logic [ted_pkg::COUNT_W-1:0]  obs_infected;
  logic [ted_pkg::COUNT_W-1:0]  obs_recovered;
  logic                         last_day;

  modport source (
    output valid, sim_susceptible, sim_infected, sim_recovered,
           obs_susceptible, obs_infected, obs_recovered, last_day,
    input  ready
  );
  modport sink (
    input  valid, sim_susceptible, sim_infected, sim_recovered,
           obs_susceptible, obs_infected, obs_recovered, last_day,
    output ready
  );
endinterface

interface ted_out_if;
  logic                        valid;
  logic                        ready;
  logic [ted_pkg::DIST_W-1:0]  dist_susceptible;
  logic [ted_pkg::DIST_W-1:0]  dist_infected;
  logic [ted_pkg::DIST_W-1:0]  dist_recovered;

  modport source (
    output valid, dist_susceptible, dist_infected, dist_recovered,
    input  ready
  );
  modport sink (
    input  valid, dist_susceptible, dist_infected, dist_recovered,
    output ready
  );
endinterface
`default_nettype wire

// File: hdl/ted_lane.sv
`timescale 1ns / 1ps
`default_nettype none
module ted_lane #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire ted_pkg::lane_ctl_t           ctl,
  input  wire logic [ted_pkg::COUNT_W-1:0]  sim,
  input  wire logic [ted_pkg::COUNT_W-1:0]  obs,
  input  wire logic [ted_pkg::POP_W-1:0]    divisor,
  output logic      [ted_pkg::DIST_W-1:0]   distance
);

  // count width is capped at the port width; input bits above COUNT_BITS are ignored
  localparam int CB  = (COUNT_BITS < ted_pkg::COUNT_W) ? COUNT_BITS : ted_pkg::COUNT_W;
  localparam int SQW = 2 * CB;
  localparam int SW  = ted_pkg::SUM_BITS;
  localparam int RW  = ted_pkg::ROOT_W;
  localparam int MW  = ted_pkg::REM_W;
  localparam int PW  = ted_pkg::POP_W;

  logic [CB-1:0]  x, y, d;
  logic [SQW-1:0] sq_r;
  logic [SW-1:0]  sum_r, sum_nxt, sat_sum;
  logic [SW:0]    full;
  logic [SW-1:0]  rad_r;
  logic [MW-1:0]  rem_r, rem_sh, trial;
  logic [RW-1:0]  root_r;
  logic [PW-1:0]  drem_r;
  logic [PW:0]    dt, dsub;
  logic           dq;

  assign x = sim[CB-1:0];
  assign y = obs[CB-1:0];
  assign d = (x >= y) ? (x - y) : (y - x);

  assign full    = {1'b0, sum_r} + {{(SW + 1 - SQW){1'b0}}, sq_r};
  assign sat_sum = (full >= {1'b0, ted_pkg::SUM_MAX}) ? ted_pkg::SUM_MAX : full[SW-1:0];

  always_comb begin
    sum_nxt = sum_r;
    if (ctl.sq_en) begin
      sum_nxt = ctl.sq_last ? '0 : sat_sum;
    end
  end

  // sqrt: next pair of the radicand, zero pairs once it is shifted out
  assign rem_sh = {rem_r[MW-3:0], rad_r[SW-1:SW-2]};
  assign trial  = {{(MW - RW - 2){1'b0}}, root_r, 2'b01};

  // restoring divide, numerator shifts out of root_r as quotient shifts in
  assign dt   = {drem_r, root_r[RW-1]};
  assign dq   = (dt >= {1'b0, divisor});
  assign dsub = dt - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else begin
      sum_r <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      sq_r <= SQW'(d) * SQW'(d);
    end
    if (ctl.sq_en && ctl.sq_last) begin
      rad_r  <= sat_sum;
      rem_r  <= '0;
      root_r <= '0;
      drem_r <= '0;
    end else if (ctl.sqrt_step) begin
      rad_r <= {rad_r[SW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[RW-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[RW-2:0], 1'b0};
      end
    end else if (ctl.div_step) begin
      drem_r <= dq ? dsub[PW-1:0] : dt[PW-1:0];
      root_r <= {root_r[RW-2:0], dq};
    end
  end

  assign distance = (|root_r[RW-1:ted_pkg::DIST_W]) ? ted_pkg::DIST_MAX
                                                    : root_r[ted_pkg::DIST_W-1:0];

endmodule
`default_nettype wire

// File: hdl/ted_merge.sv
`timescale 1ns / 1ps
`default_nettype none
module ted_merge (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        load,
  input  wire logic [ted_pkg::DIST_W-1:0]  dist_s,
  input  wire logic [ted_pkg::DIST_W-1:0]  dist_i,
  input  wire logic [ted_pkg::DIST_W-1:0]  dist_r,
  output logic                             busy,
  ted_out_if.source                        out_ch
);

  logic                       valid_r;
  logic [ted_pkg::DIST_W-1:0] s_r, i_r, r_r;

  // result register still holds an item nobody took
  assign busy = valid_r && !out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s_r <= dist_s;
      i_r <= dist_i;
      r_r <= dist_r;
    end
  end

  assign out_ch.valid            = valid_r;
  assign out_ch.dist_susceptible = s_r;
  assign out_ch.dist_infected    = i_r;
  assign out_ch.dist_recovered   = r_r;

endmodule
`default_nettype wire

// File: hdl/three_channel_euclidean_distance.sv
`timescale 1ns / 1ps
`default_nettype none
// channel  dir  handshake          payload
// in_ch    in   valid/ready        sim_*, obs_* counts, last_day
// out_ch   out  valid/ready        dist_susceptible/infected/recovered (UQ6.16)
// cfg      in   cfg_we, cfg_wdata  population
//
// three lanes square and add in parallel; days without last_day are taken one per cycle
// except while a last_day item closes the series: its square is latched and added, then
// 37 sqrt steps, 37 divide steps and one result load come before the next item is taken
// the divide-by-population and root units advance one bit per cycle in each lane
// rst_n (synchronous) clears the sums and sets population to 1000
// a result waiting on out_ch does not stall input until the next series is finished
module three_channel_euclidean_distance #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  ted_in_if.sink                           in_ch,
  ted_out_if.source                        out_ch,
  input  wire logic                        cfg_we,
  input  wire logic [ted_pkg::POP_W-1:0]   cfg_wdata
);

  ted_pkg::state_t   state_r, state_nxt;
  ted_pkg::lane_ctl_t ctl;

  logic [ted_pkg::STEP_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [ted_pkg::POP_W-1:0]      pop_r, divisor;
  logic                           vld_a_r, last_a_r;
  logic                           accept, load_out, out_busy;
  logic [ted_pkg::DIST_W-1:0]     dist_s, dist_i, dist_r;

  assign in_ch.ready = (state_r == ted_pkg::ST_ACC) && !(vld_a_r && last_a_r);
  assign accept      = in_ch.valid && in_ch.ready;
  assign divisor     = (pop_r == '0) ? ted_pkg::POP_W'(1) : pop_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pop_r <= ted_pkg::POP_RESET;
    end else if (cfg_we) begin
      pop_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ted_pkg::ST_ACC;
      cnt_r    <= '0;
      vld_a_r  <= 1'b0;
      last_a_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      vld_a_r  <= accept;
      last_a_r <= accept && in_ch.last_day;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    load_out      = 1'b0;
    ctl.load      = accept;
    ctl.sq_en     = vld_a_r;
    ctl.sq_last   = last_a_r;
    ctl.sqrt_step = 1'b0;
    ctl.div_step  = 1'b0;
    case (state_r)
      ted_pkg::ST_ACC: begin
        if (vld_a_r && last_a_r) begin
          state_nxt = ted_pkg::ST_SQRT;
          cnt_nxt   = '0;
        end
      end
      ted_pkg::ST_SQRT: begin
        ctl.sqrt_step = 1'b1;
        if (cnt_r == ted_pkg::LAST_STEP) begin
          state_nxt = ted_pkg::ST_DIV;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ted_pkg::ST_DIV: begin
        ctl.div_step = 1'b1;
        if (cnt_r == ted_pkg::LAST_STEP) begin
          state_nxt = ted_pkg::ST_DONE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ted_pkg::ST_DONE: begin
        if (!out_busy) begin
          load_out  = 1'b1;
          state_nxt = ted_pkg::ST_ACC;
        end
      end
      default: begin
        state_nxt = ted_pkg::ST_ACC;
      end
    endcase
  end

  ted_lane #(.COUNT_BITS(COUNT_BITS)) u_lane_s (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .sim      (in_ch.sim_susceptible),
    .obs      (in_ch.obs_susceptible),
    .divisor  (divisor),
    .distance (dist_s)
  );

  ted_lane #(.COUNT_BITS(COUNT_BITS)) u_lane_i (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .sim      (in_ch.sim_infected),
    .obs      (in_ch.obs_infected),
    .divisor  (divisor),
    .distance (dist_i)
  );

  ted_lane #(.COUNT_BITS(COUNT_BITS)) u_lane_r (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .sim      (in_ch.sim_recovered),
    .obs      (in_ch.obs_recovered),
    .divisor  (divisor),
    .distance (dist_r)
  );

  ted_merge u_merge (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (load_out),
    .dist_s (dist_s),
    .dist_i (dist_i),
    .dist_r (dist_r),
    .busy   (out_busy),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire
